// ===== design/integer_to_ascii_formatter_defines.svh =====
// Assertion macros shared by the integer-to-ASCII formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define ITAF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itaf assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ITAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itaf assertion failed");

`else

`define ITAF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ITAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/itaf_pkg.sv =====
// Shared types, constants and functions of the integer-to-ASCII formatter.
`default_nettype none

package itaf_pkg;

    localparam int MAG_W       = 64;
    localparam int BCD_DIGITS  = 20;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int HEX_NIBBLES = 8;
    localparam int LOW_W       = 32;
    localparam int CNT_W       = $clog2(BCD_DIGITS + 1);
    localparam int BITS_W      = $clog2(MAG_W + 1);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] OP_DEC32  = 2'd0;
    localparam logic [1:0] OP_DEC64  = 2'd1;
    localparam logic [1:0] OP_HEX32  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;

    // One classified request: sign, radix and unsigned magnitude.
    typedef struct packed {
        logic             neg;
        logic             hex;
        logic [MAG_W-1:0] mag;
    } t_req;

    // A request together with its valid flag, as moved between the parts.
    typedef struct packed {
        logic valid;
        t_req req;
    } t_req_slot;

    // Map one digit value to its upper-case ASCII glyph.
    function automatic logic [7:0] f_glyph(input logic [3:0] digit);
        logic [7:0] g;
        if (digit < 4'd10) begin
            g = ASCII_ZERO + {4'd0, digit};
        end else begin
            g = ASCII_UPPER_A + {4'd0, digit - 4'd10};
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== design/itaf_front.sv =====
// Front end: accept requests, classify the mode and form sign and magnitude.
`default_nettype none

module itaf_front (
    input  wire logic                 i_valid,
    input  wire logic [1:0]           i_op,
    input  wire logic signed [63:0]   i_value,
    input  wire logic                 i_full,
    output logic                      o_stall,
    output itaf_pkg::t_req_slot       o_push
);
    import itaf_pkg::*;

    logic [LOW_W-1:0] low;
    logic [LOW_W-1:0] low_neg;
    logic [MAG_W-1:0] full_neg;
    logic             use_op;

    assign low      = i_value[LOW_W-1:0];
    assign low_neg  = ~low + {{(LOW_W-1){1'b0}}, 1'b1};
    assign full_neg = ~i_value + {{(MAG_W-1){1'b0}}, 1'b1};

    // Hold off the sender while the queue is full.
    assign o_stall = i_full;

    always_comb begin
        use_op       = 1'b1;
        o_push.req.neg = 1'b0;
        o_push.req.hex = 1'b0;
        o_push.req.mag = {{(MAG_W-LOW_W){1'b0}}, low};
        case (i_op)
            OP_DEC32: begin
                o_push.req.neg = low[LOW_W-1];
                o_push.req.mag = {{(MAG_W-LOW_W){1'b0}}, low[LOW_W-1] ? low_neg : low};
            end
            OP_DEC64: begin
                o_push.req.neg = i_value[MAG_W-1];
                o_push.req.mag = i_value[MAG_W-1] ? full_neg : i_value;
            end
            OP_HEX32: begin
                o_push.req.hex = 1'b1;
            end
            default: begin
                // Drop the unused mode: accepted, but no text.
                use_op = 1'b0;
            end
        endcase
        o_push.valid = i_valid && !i_full && use_op;
    end

endmodule

`default_nettype wire

// ===== design/itaf_queue.sv =====
// Short request queue between the front end and the conversion back end.
`default_nettype none

module itaf_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire itaf_pkg::t_req_slot  i_push,
    input  wire logic                 i_pop,
    output itaf_pkg::t_req_slot       o_head,
    output logic                      o_full
);
    import itaf_pkg::*;

    t_req               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wp;
    logic [Q_PTR_W-1:0] n_rp;
    logic [Q_CNT_W-1:0] n_count;

    function automatic logic [Q_PTR_W-1:0] f_next(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + {{(Q_PTR_W-1){1'b0}}, 1'b1};
    endfunction

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rp];

    always_comb begin
        n_wp    = i_push.valid ? f_next(r_wp) : r_wp;
        n_rp    = i_pop ? f_next(r_rp) : r_rp;
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + {{(Q_CNT_W-1){1'b0}}, 1'b1};
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - {{(Q_CNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== design/itaf_back.sv =====
// Back end: shift-add-3 decimal conversion, hex nibble load, leading-zero skip and character output.
`default_nettype none

module itaf_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire itaf_pkg::t_req_slot  i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [7:0]                o_ascii_char,
    output logic                      o_last
);
    import itaf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [MAG_W-1:0]  r_bin, n_bin;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ov, n_ov;
    logic [7:0]        r_oc, n_oc;
    logic              r_ol, n_ol;
    logic              out_free;
    logic [3:0]        top_digit;

    // One shift-add-3 step over every BCD digit, with one new binary bit in.
    function automatic logic [BCD_W-1:0] f_dabble(input logic [BCD_W-1:0] bcd,
                                                  input logic bit_in);
        logic [BCD_W-1:0] adj;
        logic [3:0]       d;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            d = bcd[i*4 +: 4];
            adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    assign out_free     = !r_ov || !i_stall;
    assign top_digit    = r_bcd[BCD_W-1 -: 4];
    assign o_valid      = r_ov;
    assign o_ascii_char = r_oc;
    assign o_last       = r_ol;

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bits  = r_bits;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_ov    = r_ov && i_stall;
        n_oc    = r_oc;
        n_ol    = r_ol;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_bin = i_head.req.mag;
                    if (i_head.req.hex) begin
                        n_bcd   = {i_head.req.mag[LOW_W-1:0], {(BCD_W-LOW_W){1'b0}}};
                        n_cnt   = CNT_W'(HEX_NIBBLES);
                        n_state = S_SKIP;
                    end else begin
                        n_bcd   = '0;
                        n_bits  = BITS_W'(MAG_W);
                        n_cnt   = CNT_W'(BCD_DIGITS);
                        n_state = i_head.req.neg ? S_SIGN : S_CONV;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oc    = ASCII_MINUS;
                    n_ol    = 1'b0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd  = f_dabble(r_bcd, r_bin[MAG_W-1]);
                n_bin  = {r_bin[MAG_W-2:0], 1'b0};
                n_bits = r_bits - {{(BITS_W-1){1'b0}}, 1'b1};
                if (r_bits == {{(BITS_W-1){1'b0}}, 1'b1}) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // Drop one leading zero a cycle, keeping at least one digit.
                if (top_digit == 4'd0 && r_cnt > {{(CNT_W-1){1'b0}}, 1'b1}) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - {{(CNT_W-1){1'b0}}, 1'b1};
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_oc  = f_glyph(top_digit);
                    n_ol  = (r_cnt == {{(CNT_W-1){1'b0}}, 1'b1});
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - {{(CNT_W-1){1'b0}}, 1'b1};
                    if (r_cnt == {{(CNT_W-1){1'b0}}, 1'b1}) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bits <= n_bits;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_oc   <= n_oc;
        r_ol   <= n_ol;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

endmodule

`default_nettype wire

// ===== design/integer_to_ascii_formatter.sv =====
// Top level of the integer-to-ASCII formatter: front end, request queue and back end.
// A request is written into the queue at its accepting edge; the idle back end pops it.
// Decimal requests emit a minus sign first when negative, run a shift-add-3 loop over all
// 64 magnitude bits, skip leading zeros and emit the digits; hex requests load 8 nibbles.
// Output stalls hold the back end; the two-entry queue holds requests while it is busy.
// Reset: synchronous, active low; it empties the queue, idles the back end, drops o_valid.
`default_nettype none

`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [63:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_ascii_char,
    output logic                    o_last
);
    import itaf_pkg::*;

    // Request moving from the front end into the queue.
    t_req_slot push;
    // Oldest queued request as seen by the back end.
    t_req_slot head;
    logic      q_full;
    logic      pop;

    // Classify each request: sign, radix and magnitude; drop the unused mode.
    itaf_front u_front (
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_value (i_value),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (push)
    );

    // Decouple the front end from the slow conversion behind it.
    itaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    // Convert one request at a time and stream its characters, most significant first.
    itaf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    // Never write into a full queue.
    `ITAF_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, push.valid, !q_full)
    // Pop only an occupied queue.
    `ITAF_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, pop, head.valid)
    // A minus sign always has digits after it.
    `ITAF_ASSERT_SAME(a_minus_not_last, i_clk, i_rst_n,
        o_valid && (o_ascii_char == ASCII_MINUS), !o_last)
    // The unused mode never reaches the queue.
    `ITAF_ASSERT_SAME(a_drop_unused, i_clk, i_rst_n,
        i_valid && !o_stall && (i_op == OP_UNUSED), !push.valid)

endmodule

`default_nettype wire
